// File: rtl/fqs_pkg.sv
package fqs_pkg;

  localparam int DefaultDepth = 16;

  localparam int DataW  = 32;
  localparam int CmdW   = 2;
  localparam int StatW  = 2;
  localparam int PosW   = 4;
  localparam int CountW = 5;

  localparam logic [CmdW-1:0] CmdPush   = 2'd0;
  localparam logic [CmdW-1:0] CmdPop    = 2'd1;
  localparam logic [CmdW-1:0] CmdSearch = 2'd2;
  localparam logic [CmdW-1:0] CmdClear  = 2'd3;

  localparam logic [StatW-1:0] StatOk    = 2'd0;
  localparam logic [StatW-1:0] StatEmpty = 2'd1;
  localparam logic [StatW-1:0] StatFull  = 2'd2;

endpackage

// File: rtl/fifo_queue_with_search_top.sv
// fifo queue with search: one command per start transfer, one result per command on done_o
// push, clear, and empty pop or search finish from idle; a pop passes through StPop
// search: one entry compared per cycle from head to tail, ending at a match or the tail
// busy_o drops in the cycle the result is shown
// the next transfer can land on the edge that ends that cycle; the receiver cannot stall
// reset (async, active low) empties the queue; entry contents are not cleared
module fifo_queue_with_search_top #(
  parameter int DEPTH = fqs_pkg::DefaultDepth
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [fqs_pkg::CmdW-1:0]         command_i,
  input  logic signed [fqs_pkg::DataW-1:0] value_i,
  output logic                             done_o,
  output logic [fqs_pkg::StatW-1:0]        status_o,
  output logic signed [fqs_pkg::DataW-1:0] data_out_o,
  output logic                             found_o,
  output logic [fqs_pkg::PosW-1:0]         position_o,
  output logic [fqs_pkg::CountW-1:0]       count_o
);

  localparam int AddrW = $clog2(DEPTH);
  localparam int CntW  = $clog2(DEPTH + 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StPop  = 2'd1;
  localparam logic [1:0] StSrch = 2'd2;

  logic [1:0] state_q, state_d;
  logic [AddrW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [AddrW-1:0] scan_ptr_q, scan_ptr_d;
  logic [AddrW-1:0] scan_off_q, scan_off_d;
  logic [fqs_pkg::DataW-1:0] key_q, key_d;

  logic [fqs_pkg::DataW-1:0] mem [DEPTH];
  logic [fqs_pkg::DataW-1:0] rd_data_q;
  logic [AddrW-1:0] rd_addr;
  logic we;

  logic done_q, done_d;
  logic [fqs_pkg::StatW-1:0] status_q, status_d;
  logic [fqs_pkg::DataW-1:0] data_q, data_d;
  logic found_q, found_d;
  logic [fqs_pkg::PosW-1:0] pos_q, pos_d;
  logic [fqs_pkg::CountW-1:0] count_q, count_d;

  logic accept;
  logic full, empty;
  logic last_entry;
  logic [CntW+fqs_pkg::CountW-1:0] cnt_ext;
  logic [AddrW+fqs_pkg::PosW-1:0] off_ext;

  function automatic logic [AddrW-1:0] ring_next(input logic [AddrW-1:0] idx);
    logic [AddrW-1:0] r;
    if (idx == AddrW'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = idx + AddrW'(1);
    end
    return r;
  endfunction

  assign accept = start_i && (state_q == StIdle);
  assign full   = (cnt_q == CntW'(DEPTH));
  assign empty  = (cnt_q == '0);
  assign last_entry = (CntW'({1'b0, scan_off_q} + (AddrW+1)'(1)) == cnt_q);
  assign off_ext = {{fqs_pkg::PosW{1'b0}}, scan_off_q};
  assign we = accept && (command_i == fqs_pkg::CmdPush) && !full;

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    tail_d     = tail_q;
    cnt_d      = cnt_q;
    scan_ptr_d = scan_ptr_q;
    scan_off_d = scan_off_q;
    key_d      = key_q;
    rd_addr    = head_q;
    done_d     = 1'b0;
    status_d   = fqs_pkg::StatOk;
    data_d     = '0;
    found_d    = 1'b0;
    pos_d      = '0;
    case (state_q)
      StIdle: begin
        if (accept) begin
          case (command_i)
            fqs_pkg::CmdPush: begin
              done_d = 1'b1;
              if (full) begin
                status_d = fqs_pkg::StatFull;
              end else begin
                tail_d = ring_next(tail_q);
                cnt_d  = cnt_q + CntW'(1);
              end
            end
            fqs_pkg::CmdPop: begin
              if (empty) begin
                done_d   = 1'b1;
                status_d = fqs_pkg::StatEmpty;
              end else begin
                state_d = StPop;
              end
            end
            fqs_pkg::CmdSearch: begin
              if (empty) begin
                done_d   = 1'b1;
                status_d = fqs_pkg::StatEmpty;
              end else begin
                key_d      = value_i;
                scan_ptr_d = head_q;
                scan_off_d = '0;
                state_d    = StSrch;
              end
            end
            default: begin
              done_d = 1'b1;
              head_d = '0;
              tail_d = '0;
              cnt_d  = '0;
            end
          endcase
        end
      end
      StPop: begin
        done_d  = 1'b1;
        data_d  = rd_data_q;
        head_d  = ring_next(head_q);
        cnt_d   = cnt_q - CntW'(1);
        state_d = StIdle;
      end
      StSrch: begin
        rd_addr    = ring_next(scan_ptr_q);
        scan_ptr_d = rd_addr;
        scan_off_d = scan_off_q + AddrW'(1);
        if (rd_data_q == key_q) begin
          done_d  = 1'b1;
          found_d = 1'b1;
          pos_d   = off_ext[fqs_pkg::PosW-1:0];
          state_d = StIdle;
        end else if (last_entry) begin
          done_d  = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
    cnt_ext = {{fqs_pkg::CountW{1'b0}}, cnt_d};
    count_d = cnt_ext[fqs_pkg::CountW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[tail_q] <= value_i;
    end
    rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      head_q  <= '0;
      tail_q  <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_ptr_q <= scan_ptr_d;
    scan_off_q <= scan_off_d;
    key_q      <= key_d;
    status_q   <= status_d;
    data_q     <= data_d;
    found_q    <= found_d;
    pos_q      <= pos_d;
    count_q    <= count_d;
  end

  assign busy_o     = (state_q != StIdle);
  assign done_o     = done_q;
  assign status_o   = status_q;
  assign data_out_o = data_q;
  assign found_o    = found_q;
  assign position_o = pos_q;
  assign count_o    = count_q;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("entry count above depth");

  a_srch_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSrch) |-> (cnt_q != '0) && (scan_off_q < AddrW'(cnt_q - CntW'(1)) ||
    CntW'(scan_off_q) == cnt_q - CntW'(1)))
    else $error("search offset outside held entries");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && command_i == fqs_pkg::CmdPush && !full) |=>
    (cnt_q == $past(cnt_q) + CntW'(1)) && done_o && status_o == fqs_pkg::StatOk)
    else $error("accepted push did not add an entry");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && found_o) |-> (status_o == fqs_pkg::StatOk && data_out_o == '0))
    else $error("search hit with bad status or data");
`endif

endmodule
